// ----- hw/rtl/websocket_url_parser_top_defines.svh -----
// ----------------------------------------------------------------------------
// websocket url parser assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_URL_PARSER_TOP_DEFINES_SVH
`define WEBSOCKET_URL_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define WUP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wup assertion failed");

// next-cycle implication
`define WUP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wup assertion failed");

`endif

// ----- hw/rtl/wup_pkg.sv -----
// ----------------------------------------------------------------------------
// wup_pkg
// types, codes and constants of the websocket url parser
// ----------------------------------------------------------------------------
`default_nettype none

package wup_pkg;

  localparam int DEFAULT_MAX_URL_LENGTH = 1024;
  localparam int DEFAULT_QUEUE_DEPTH    = 2;

  localparam int PORT_SECURE       = 443;
  localparam int PORT_PLAIN        = 80;
  localparam int PORT_MAX          = 65535;
  localparam int PORT_MAX_DIGITS   = 5;
  localparam int AUTH_START_PLAIN  = 5;
  localparam int AUTH_START_SECURE = 6;
  localparam int SCHEME_LEN_PLAIN  = 5;
  localparam int SCHEME_LEN_SECURE = 6;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_RBR   = 8'h5d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_S     = 8'h73;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SCHEME = 3'd1,
    ST_MALFORMED  = 3'd2,
    ST_NO_HOST    = 3'd3,
    ST_BAD_PORT   = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_SCHEME,
    PH_AUTH,
    PH_PATH,
    PH_BADSCHEME
  } phase_t;

  typedef enum logic [1:0] {
    BR_NONE,
    BR_OPEN,
    BR_CLOSED
  } bracket_t;

  // classified byte word handed from front to back
  typedef struct packed {
    logic       last;
    logic       over;
    logic       is_slash;
    logic       is_colon;
    logic       is_lbr;
    logic       is_rbr;
    logic       is_digit;
    logic [3:0] digit;
    logic       sch_secure;
    logic       sch_plain;
    logic       at_plain_end;
    logic       at_secure_end;
  } byte_cls_t;

  function automatic logic [7:0] secure_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CH_W;
      3'd1:    ch = CH_S;
      3'd2:    ch = CH_S;
      3'd3:    ch = CH_COLON;
      default: ch = CH_SLASH;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] plain_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CH_W;
      3'd1:    ch = CH_S;
      3'd2:    ch = CH_COLON;
      default: ch = CH_SLASH;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wup_front.sv -----
// ----------------------------------------------------------------------------
// wup_front
// accepts url bytes, counts position and classifies each byte
// ----------------------------------------------------------------------------
`default_nettype none

module wup_front import wup_pkg::*; #(
  parameter int MAX_URL_LENGTH = DEFAULT_MAX_URL_LENGTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [7:0]                        url_byte,
  input  wire logic                              last_byte,
  input  wire logic                              accept,
  output byte_cls_t                              cls,
  output logic [$clog2(MAX_URL_LENGTH)-1:0]      pos_out
);

  localparam int AW = $clog2(MAX_URL_LENGTH);
  localparam int PW = $clog2(MAX_URL_LENGTH + 2);

  logic [PW-1:0] position;
  logic [PW-1:0] position_next;

  always_comb begin
    position_next = position;
    if (accept) begin
      if (last_byte) begin
        position_next = '0;
      end else if (position <= PW'(MAX_URL_LENGTH)) begin
        position_next = position + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else begin
      position <= position_next;
    end
  end

  always_comb begin
    cls.last          = last_byte;
    cls.over          = (position >= PW'(MAX_URL_LENGTH));
    cls.is_slash      = (url_byte == CH_SLASH);
    cls.is_colon      = (url_byte == CH_COLON);
    cls.is_lbr        = (url_byte == CH_LBR);
    cls.is_rbr        = (url_byte == CH_RBR);
    cls.is_digit      = (url_byte >= CH_ZERO) && (url_byte <= CH_NINE);
    cls.digit         = url_byte[3:0];
    cls.sch_secure    = (position < PW'(SCHEME_LEN_SECURE)) &&
                        (url_byte == secure_char(position[2:0]));
    cls.sch_plain     = (position < PW'(SCHEME_LEN_PLAIN)) &&
                        (url_byte == plain_char(position[2:0]));
    cls.at_plain_end  = (position == PW'(SCHEME_LEN_PLAIN - 1));
    cls.at_secure_end = (position == PW'(SCHEME_LEN_SECURE - 1));
  end

  assign pos_out = position[AW-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/wup_queue.sv -----
// ----------------------------------------------------------------------------
// wup_queue
// small register queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module wup_queue import wup_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTW = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTW-1:0]   wr_ptr;
  logic [PTW-1:0]   rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTW'(DEPTH - 1)) ? '0 : wr_ptr + PTW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTW'(DEPTH - 1)) ? '0 : rd_ptr + PTW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wup_back.sv -----
// ----------------------------------------------------------------------------
// wup_back
// runs the url parse state per byte word and registers the result
// ----------------------------------------------------------------------------
`default_nettype none

module wup_back import wup_pkg::*; #(
  parameter int MAX_URL_LENGTH = DEFAULT_MAX_URL_LENGTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire byte_cls_t                     q_cls,
  input  wire logic [$clog2(MAX_URL_LENGTH)-1:0] q_pos,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [2:0]                         status,
  output logic                               secure,
  output logic [15:0]                        port_number,
  output logic [9:0]                         host_offset,
  output logic [10:0]                        host_length,
  output logic [9:0]                         path_offset,
  output logic [10:0]                        path_length
);

  localparam int AW = $clog2(MAX_URL_LENGTH);
  localparam int LW = AW + 1;

  phase_t      phase, phase_upd, phase_next;
  logic [1:0]  cand, cand_new, cand_u;
  logic        sec_flag, sec_u;
  logic [AW-1:0] auth_start, auth_u;
  bracket_t    bmode, bmode_u;
  logic [AW-1:0] bclose, bclose_u;
  logic [AW-1:0] colon_pos, colon_u;
  logic        pseen, pseen_u;
  logic [16:0] pval, pval_u, pval_inc;
  logic [2:0]  pdig, pdig_u;
  logic        pbad, pbad_u;
  logic        malf, malf_u;
  logic [AW-1:0] slash_pos, slash_u;

  logic        pop;
  logic [LW-1:0] len;
  logic [LW-1:0] auth_end;
  logic [LW-1:0] hlen;
  status_t     r_status;
  logic        r_secure;
  logic [15:0] r_port;
  logic [31:0] r_hoff, r_hlen, r_poff, r_plen;

  // only a last byte needs the result register
  assign q_ready  = !res_valid || res_ready || !q_cls.last;
  assign pop      = q_valid && q_ready;
  assign cand_new = cand & {q_cls.sch_secure, q_cls.sch_plain};
  assign pval_inc = 17'(pval * 17'd10 + 17'(q_cls.digit));

  // next state
  always_comb begin
    phase_upd = phase;
    if (!q_cls.over) begin
      unique case (phase)
        PH_SCHEME: begin
          if (cand_new[0] && q_cls.at_plain_end) begin
            phase_upd = PH_AUTH;
          end else if (cand_new[1] && q_cls.at_secure_end) begin
            phase_upd = PH_AUTH;
          end else if (cand_new == 2'b00) begin
            phase_upd = PH_BADSCHEME;
          end
        end
        PH_AUTH: begin
          if (q_cls.is_slash) begin
            phase_upd = PH_PATH;
          end
        end
        PH_PATH, PH_BADSCHEME: begin
        end
      endcase
    end
    phase_next = phase;
    if (pop) begin
      phase_next = q_cls.last ? PH_SCHEME : phase_upd;
    end
  end

  // datapath update and result
  always_comb begin
    cand_u   = cand;
    sec_u    = sec_flag;
    auth_u   = auth_start;
    bmode_u  = bmode;
    bclose_u = bclose;
    colon_u  = colon_pos;
    pseen_u  = pseen;
    pval_u   = pval;
    pdig_u   = pdig;
    pbad_u   = pbad;
    malf_u   = malf;
    slash_u  = slash_pos;
    if (!q_cls.over) begin
      if (phase == PH_SCHEME) begin
        cand_u = cand_new;
        if (cand_new[0] && q_cls.at_plain_end) begin
          sec_u  = 1'b0;
          auth_u = AW'(AUTH_START_PLAIN);
        end else if (cand_new[1] && q_cls.at_secure_end) begin
          sec_u  = 1'b1;
          auth_u = AW'(AUTH_START_SECURE);
        end
      end else if (phase == PH_AUTH) begin
        if (q_cls.is_slash) begin
          slash_u = q_pos;
        end else if (bmode == BR_NONE && q_pos == auth_start && q_cls.is_lbr) begin
          bmode_u = BR_OPEN;
        end else if (bmode == BR_OPEN) begin
          if (q_cls.is_rbr) begin
            bmode_u  = BR_CLOSED;
            bclose_u = q_pos;
          end
        end else if (bmode == BR_CLOSED && q_pos == bclose + AW'(1)) begin
          if (q_cls.is_colon) begin
            pseen_u = 1'b1;
            pval_u  = '0;
            pdig_u  = '0;
            pbad_u  = 1'b0;
          end else begin
            malf_u = 1'b1;
          end
        end else if (bmode == BR_NONE && q_cls.is_colon) begin
          colon_u = q_pos;
          pseen_u = 1'b1;
          pval_u  = '0;
          pdig_u  = '0;
          pbad_u  = 1'b0;
        end else if (bmode == BR_CLOSED || pseen) begin
          if (q_cls.is_digit && pdig < 3'(PORT_MAX_DIGITS)) begin
            pval_u = pval_inc;
            pdig_u = pdig + 3'd1;
          end else begin
            pbad_u = 1'b1;
          end
        end
      end
    end

    len      = LW'(q_pos) + LW'(1);
    auth_end = (phase_upd == PH_PATH) ? LW'(slash_u) : len;
    if (bmode_u == BR_CLOSED) begin
      hlen = LW'(bclose_u) - LW'(auth_u) - LW'(1);
    end else begin
      hlen = (pseen_u ? LW'(colon_u) : auth_end) - LW'(auth_u);
    end

    r_status = ST_OK;
    r_secure = sec_u;
    r_port   = '0;
    r_hoff   = '0;
    r_hlen   = '0;
    r_poff   = '0;
    r_plen   = '0;
    if (q_cls.over) begin
      r_status = ST_TOO_LONG;
      if (phase_upd == PH_SCHEME || phase_upd == PH_BADSCHEME) begin
        r_secure = 1'b0;
      end
    end else if (phase_upd == PH_SCHEME || phase_upd == PH_BADSCHEME) begin
      r_status = ST_BAD_SCHEME;
      r_secure = 1'b0;
    end else if (bmode_u == BR_OPEN || malf_u) begin
      r_status = ST_MALFORMED;
    end else if (hlen == '0) begin
      r_status = ST_NO_HOST;
    end else if (pseen_u && (pbad_u || pdig_u == '0 || pval_u == '0 ||
                             pval_u > 17'(PORT_MAX))) begin
      r_status = ST_BAD_PORT;
    end else begin
      r_port = pseen_u ? pval_u[15:0] : (sec_u ? 16'(PORT_SECURE) : 16'(PORT_PLAIN));
      r_hoff = (bmode_u == BR_CLOSED) ? 32'(auth_u) + 32'd1 : 32'(auth_u);
      r_hlen = 32'(hlen);
      if (phase_upd == PH_PATH) begin
        r_poff = 32'(slash_u);
        r_plen = 32'(len - LW'(slash_u));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SCHEME;
      cand       <= 2'b11;
      sec_flag   <= 1'b0;
      auth_start <= '0;
      bmode      <= BR_NONE;
      bclose     <= '0;
      colon_pos  <= '0;
      pseen      <= 1'b0;
      pval       <= '0;
      pdig       <= '0;
      pbad       <= 1'b0;
      malf       <= 1'b0;
      slash_pos  <= '0;
    end else begin
      phase <= phase_next;
      if (pop) begin
        if (q_cls.last) begin
          cand       <= 2'b11;
          sec_flag   <= 1'b0;
          auth_start <= '0;
          bmode      <= BR_NONE;
          bclose     <= '0;
          colon_pos  <= '0;
          pseen      <= 1'b0;
          pval       <= '0;
          pdig       <= '0;
          pbad       <= 1'b0;
          malf       <= 1'b0;
          slash_pos  <= '0;
        end else begin
          cand       <= cand_u;
          sec_flag   <= sec_u;
          auth_start <= auth_u;
          bmode      <= bmode_u;
          bclose     <= bclose_u;
          colon_pos  <= colon_u;
          pseen      <= pseen_u;
          pval       <= pval_u;
          pdig       <= pdig_u;
          pbad       <= pbad_u;
          malf       <= malf_u;
          slash_pos  <= slash_u;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && q_cls.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cls.last) begin
      status      <= r_status;
      secure      <= r_secure;
      port_number <= r_port;
      host_offset <= r_hoff[9:0];
      host_length <= r_hlen[10:0];
      path_offset <= r_poff[9:0];
      path_length <= r_plen[10:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/websocket_url_parser_top.sv -----
// ----------------------------------------------------------------------------
// websocket_url_parser_top
// websocket url scheme, authority and path parser
// ----------------------------------------------------------------------------
// Takes one url byte per cycle while url_ready is high and, on the byte
// flagged last, delivers one result word with status, tls flag, port and
// host/path offsets and lengths. Sustained rate is one byte per cycle unless
// a last byte waits on an unread result word, set by the back parser, which
// updates its running parse state once per byte word. The last byte is
// written into the queue and then parsed from it into the result register.
// While a result word waits, the back keeps taking bytes up to the next last
// byte; then the QUEUE_DEPTH-word queue fills and url_ready drops. Urls
// longer than MAX_URL_LENGTH report too long.
`default_nettype none

module websocket_url_parser_top import wup_pkg::*; #(
  parameter int MAX_URL_LENGTH = DEFAULT_MAX_URL_LENGTH,
  parameter int QUEUE_DEPTH    = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        url_valid,
  output logic             url_ready,
  input  wire logic [7:0]  url_byte,
  input  wire logic        last_byte,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [2:0]       status,
  output logic             secure,
  output logic [15:0]      port_number,
  output logic [9:0]       host_offset,
  output logic [10:0]      host_length,
  output logic [9:0]       path_offset,
  output logic [10:0]      path_length
);

  localparam int AW = $clog2(MAX_URL_LENGTH);
  localparam int EW = $bits(byte_cls_t) + AW;

  byte_cls_t     f_cls;
  logic [AW-1:0] f_pos;
  byte_cls_t     b_cls;
  logic [AW-1:0] b_pos;
  logic [EW-1:0] q_out;
  logic          q_valid;
  logic          q_ready;

  wup_front #(
    .MAX_URL_LENGTH(MAX_URL_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .url_byte (url_byte),
    .last_byte(last_byte),
    .accept   (url_valid && url_ready),
    .cls      (f_cls),
    .pos_out  (f_pos)
  );

  wup_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(url_valid),
    .push_ready(url_ready),
    .push_data ({f_cls, f_pos}),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_out)
  );

  assign {b_cls, b_pos} = q_out;

  wup_back #(
    .MAX_URL_LENGTH(MAX_URL_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cls      (b_cls),
    .q_pos      (b_pos),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .status     (status),
    .secure     (secure),
    .port_number(port_number),
    .host_offset(host_offset),
    .host_length(host_length),
    .path_offset(path_offset),
    .path_length(path_length)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/wup_checker.sv -----
// ----------------------------------------------------------------------------
// wup_checker
// port-level assertions on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_url_parser_top_defines.svh"

module wup_checker import wup_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  status,
  input wire logic        secure,
  input wire logic [15:0] port_number,
  input wire logic [10:0] host_length,
  input wire logic [9:0]  path_offset,
  input wire logic [10:0] path_length
);

  // stalled result word holds
  `WUP_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(status) && $stable(port_number) && $stable(host_length))

  // error words carry zero fields
  `WUP_ASSERT_IMP(a_err_zero, res_valid && status != ST_OK, port_number == 16'd0 && host_length == 11'd0 && path_offset == 10'd0 && path_length == 11'd0)

  // good words carry a host and a port
  `WUP_ASSERT_IMP(a_ok_fields, res_valid && status == ST_OK, port_number != 16'd0 && host_length != 11'd0)

  // bad scheme never reports tls
  `WUP_ASSERT_IMP(a_scheme_sec, res_valid && status == ST_BAD_SCHEME, !secure)

endmodule

bind websocket_url_parser_top wup_checker u_wup_checker (.*);

`default_nettype wire
